// File: src/display_dirty_span_flusher_macros.svh
// Assertion macros for the dirty span flusher.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef DISPLAY_DIRTY_SPAN_FLUSHER_MACROS_SVH
`define DISPLAY_DIRTY_SPAN_FLUSHER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define DDSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define DDSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ddsf_pkg.sv
// Shared types and constants of the dirty span flusher.
// No dependencies; used by ddsf_span_scan and display_dirty_span_flusher.
package ddsf_pkg;

    // request codes
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_COMMIT = 2'd1;
    localparam logic [1:0] REQ_STEP   = 2'd2;

    // transmit phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CURSOR = 2'd1;
    localparam logic [1:0] PH_HEADER = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    // configuration register indexes
    localparam logic CFG_COLUMN_OFFSET  = 1'b0;
    localparam logic CFG_DEVICE_ADDRESS = 1'b1;

    // bus bytes
    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    // register reset values
    localparam logic [7:0] DEV_ADDR_RST   = 8'h78;
    localparam logic [6:0] COL_OFFSET_RST = 7'd2;

    typedef struct packed {
        logic restart;
        logic cmp_valid;
    } scan_ctl_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       frame_done;
        logic       write_refused;
    } result_t;

endpackage

// File: src/ddsf_span_scan.sv
// Compare unit: tracks first and last differing column of one page scan.
// Depends on ddsf_pkg (scan_ctl_t).
module ddsf_span_scan #(
    parameter int WIDTH = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ddsf_pkg::scan_ctl_t          ctl,
    input  logic [$clog2(WIDTH)-1:0]     col,
    input  logic [7:0]                   frame_byte,
    input  logic [7:0]                   shown_byte,
    output logic                         hit_now,
    output logic [$clog2(WIDTH)-1:0]     first_now,
    output logic [$clog2(WIDTH)-1:0]     last_now
);

    localparam int CI_W = $clog2(WIDTH);

    logic            hit_reg;
    logic [CI_W-1:0] first_reg;
    logic [CI_W-1:0] last_reg;
    logic            diff;

    assign diff      = ctl.cmp_valid && (frame_byte != shown_byte);
    assign hit_now   = hit_reg || diff;
    assign first_now = hit_reg ? first_reg : col;
    assign last_now  = diff ? col : last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.restart)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_now;
        last_reg  <= last_now;
    end

endmodule

// File: src/display_dirty_span_flusher.sv
// Dirty span flusher: paged frame store plus panel shadow, emits changed spans.
// Depends on ddsf_pkg, ddsf_span_scan and display_dirty_span_flusher_macros.svh.
//
// Use: items arrive on in_valid/in_ready (req_type, page, column, pixel_byte);
// results leave on out_valid/out_ready, one beat per result. An item gives
// zero or one result beat. Writes and commits while a frame is pending
// give a write_refused beat. Each transmit step of a pending frame yields
// one bus byte beat (cursor transaction, data header, or one span byte)
// or a frame_done beat. cfg_write_en/cfg_index/cfg_data set column_offset
// (0) and device_address (1) at once, no wait.
// A data step first reads its byte from the frame store. A beat is
// offered the cycle after the item's last cycle. A dirty page search
// walks the two stores one byte per cycle through one compare unit, page
// by page until a page differs or the last page is done. Reset: both
// stores are cleared by a sweep over all PAGES*WIDTH cells (frame to 0,
// shadow to 0xFF); in_ready stays low.
// The result sits in an output register; a new item is taken while that
// beat waits, but an item that yields a result holds until the register
// frees, so a stalled receiver stalls the block after one more item.
`include "display_dirty_span_flusher_macros.svh"

module display_dirty_span_flusher #(
    parameter int PAGES = 8,
    parameter int WIDTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [2:0] page,
    input  logic [6:0] column,
    input  logic [7:0] pixel_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       byte_valid,
    output logic [7:0] bus_byte,
    output logic       start_before,
    output logic       stop_after,
    output logic       frame_done,
    output logic       write_refused,
    // config port
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CI_W  = $clog2(WIDTH);
    localparam int CC_W  = $clog2(WIDTH + 1);
    localparam int PG_W  = $clog2(PAGES + 1);
    localparam int CELLS = PAGES * WIDTH;
    localparam int AD_W  = $clog2(CELLS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DREAD = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    function automatic logic [AD_W-1:0] cell_addr(input logic [PG_W-1:0] pg,
                                                  input logic [CC_W-1:0] cl);
        cell_addr = AD_W'(pg) * AD_W'(WIDTH) + AD_W'(cl);
    endfunction

    // control state
    logic [2:0]      state_reg,        state_next;
    logic [AD_W-1:0] clr_addr_reg,     clr_addr_next;
    logic            frame_pending_reg, frame_pending_next;
    logic [1:0]      tx_phase_reg,     tx_phase_next;
    logic [2:0]      seq_index_reg,    seq_index_next;
    logic [PG_W-1:0] cur_page_reg,     cur_page_next;
    logic [CC_W-1:0] cur_column_reg,   cur_column_next;
    logic [CI_W-1:0] span_last_reg,    span_last_next;
    logic [CI_W-1:0] scan_col_reg,     scan_col_next;
    logic            issue_done_reg,   issue_done_next;
    logic            rd_v_reg,         rd_v_next;
    logic [CI_W-1:0] rd_col_reg,       rd_col_next;
    ddsf_pkg::result_t res_reg,        res_next;

    // config
    logic [6:0] column_offset_reg;
    logic [7:0] device_address_reg;

    // output beat register
    logic              out_valid_reg;
    ddsf_pkg::result_t out_res_reg;
    logic              out_load;

    // stores
    logic [7:0]      frame_mem [CELLS];
    logic [7:0]      shown_mem [CELLS];
    logic            frame_we,    shown_we;
    logic [AD_W-1:0] frame_waddr, shown_waddr;
    logic [7:0]      frame_wdata, shown_wdata;
    logic [AD_W-1:0] frame_raddr, shown_raddr;
    logic [7:0]      frame_q_reg, shown_q_reg;

    // compare unit
    ddsf_pkg::scan_ctl_t scan_ctl;
    logic                hit_now;
    logic [CI_W-1:0]     first_now;
    logic [CI_W-1:0]     last_now;

    // helpers
    logic [AD_W-1:0] data_addr;
    logic [7:0]      cursor_x;
    logic [7:0]      cursor_byte;
    logic            busy;
    logic [PG_W-1:0] next_page;
    logic [CC_W-1:0] next_col;
    logic            span_end;

    ddsf_span_scan #(
        .WIDTH(WIDTH)
    ) u_span_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .col        (rd_col_reg),
        .frame_byte (frame_q_reg),
        .shown_byte (shown_q_reg),
        .hit_now    (hit_now),
        .first_now  (first_now),
        .last_now   (last_now)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign data_addr = cell_addr(cur_page_reg, cur_column_reg);
    assign busy      = frame_pending_reg || (tx_phase_reg != ddsf_pkg::PH_IDLE);
    assign next_page = cur_page_reg + PG_W'(1);
    assign next_col  = cur_column_reg + CC_W'(1);
    assign span_end  = (next_col > CC_W'(span_last_reg)) || (next_col >= CC_W'(WIDTH));

    // cursor transaction bytes; column wraps at 8 bits
    assign cursor_x = 8'(cur_column_reg) + {1'b0, column_offset_reg};

    always_comb
    begin
        unique case (seq_index_reg)
            3'd0:    cursor_byte = device_address_reg;
            3'd1:    cursor_byte = ddsf_pkg::CTRL_CMD;
            3'd2:    cursor_byte = ddsf_pkg::CMD_PAGE
                                   | (8'(cur_page_reg) & ddsf_pkg::NIBBLE_MASK);
            3'd3:    cursor_byte = ddsf_pkg::CMD_COL_HI | (cursor_x >> 4);
            default: cursor_byte = cursor_x & ddsf_pkg::NIBBLE_MASK;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        clr_addr_next      = clr_addr_reg;
        frame_pending_next = frame_pending_reg;
        tx_phase_next      = tx_phase_reg;
        seq_index_next     = seq_index_reg;
        cur_page_next      = cur_page_reg;
        cur_column_next    = cur_column_reg;
        span_last_next     = span_last_reg;
        scan_col_next      = scan_col_reg;
        issue_done_next    = issue_done_reg;
        rd_v_next          = 1'b0;
        rd_col_next        = rd_col_reg;
        res_next           = res_reg;

        frame_we    = 1'b0;
        frame_waddr = data_addr;
        frame_wdata = pixel_byte;
        shown_we    = 1'b0;
        shown_waddr = data_addr;
        shown_wdata = frame_q_reg;
        frame_raddr = data_addr;
        shown_raddr = data_addr;

        scan_ctl.restart   = 1'b0;
        scan_ctl.cmp_valid = rd_v_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                frame_we    = 1'b1;
                frame_waddr = clr_addr_reg;
                frame_wdata = 8'h00;
                shown_we    = 1'b1;
                shown_waddr = clr_addr_reg;
                shown_wdata = 8'hFF;
                if (clr_addr_reg == AD_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AD_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    unique case (req_type)
                        ddsf_pkg::REQ_WRITE,
                        ddsf_pkg::REQ_COMMIT:
                        begin
                            if (busy)
                            begin
                                res_next.write_refused = 1'b1;
                                state_next             = S_OUT;
                            end
                            else if (req_type == ddsf_pkg::REQ_COMMIT)
                            begin
                                frame_pending_next = 1'b1;
                                cur_page_next      = '0;
                            end
                            else if ((32'(page) < PAGES) && (32'(column) < WIDTH))
                            begin
                                frame_we    = 1'b1;
                                frame_waddr = cell_addr(PG_W'(page), CC_W'(column));
                            end
                        end

                        ddsf_pkg::REQ_STEP:
                        begin
                            unique case (tx_phase_reg)
                                ddsf_pkg::PH_IDLE:
                                begin
                                    if (frame_pending_reg)
                                    begin
                                        if (cur_page_reg >= PG_W'(PAGES))
                                        begin
                                            frame_pending_next  = 1'b0;
                                            cur_page_next       = '0;
                                            res_next.frame_done = 1'b1;
                                            state_next          = S_OUT;
                                        end
                                        else
                                        begin
                                            scan_col_next    = '0;
                                            issue_done_next  = 1'b0;
                                            scan_ctl.restart = 1'b1;
                                            state_next       = S_SCAN;
                                        end
                                    end
                                end

                                ddsf_pkg::PH_CURSOR:
                                begin
                                    res_next.byte_valid   = 1'b1;
                                    res_next.bus_byte     = cursor_byte;
                                    res_next.start_before = (seq_index_reg == 3'd0);
                                    res_next.stop_after   = (seq_index_reg >= 3'd4);
                                    if (seq_index_reg >= 3'd4)
                                    begin
                                        tx_phase_next  = ddsf_pkg::PH_HEADER;
                                        seq_index_next = '0;
                                    end
                                    else
                                    begin
                                        seq_index_next = seq_index_reg + 3'd1;
                                    end
                                    state_next = S_OUT;
                                end

                                ddsf_pkg::PH_HEADER:
                                begin
                                    res_next.byte_valid = 1'b1;
                                    if (seq_index_reg == 3'd0)
                                    begin
                                        res_next.bus_byte     = device_address_reg;
                                        res_next.start_before = 1'b1;
                                        seq_index_next        = 3'd1;
                                    end
                                    else
                                    begin
                                        res_next.bus_byte = ddsf_pkg::CTRL_DATA;
                                        seq_index_next    = '0;
                                        tx_phase_next     = ddsf_pkg::PH_DATA;
                                    end
                                    state_next = S_OUT;
                                end

                                default:
                                begin
                                    // data byte: frame read issued at data_addr now
                                    state_next = S_DREAD;
                                end
                            endcase
                        end

                        default:
                        begin
                            // unused request code: dropped
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue side: one cell of the current page per cycle
                if (!issue_done_reg)
                begin
                    frame_raddr = cell_addr(cur_page_reg, CC_W'(scan_col_reg));
                    shown_raddr = frame_raddr;
                    rd_v_next   = 1'b1;
                    rd_col_next = scan_col_reg;
                    if (scan_col_reg == CI_W'(WIDTH - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + CI_W'(1);
                    end
                end
                // compare side: page decided on its last column
                if (rd_v_reg && (rd_col_reg == CI_W'(WIDTH - 1)))
                begin
                    res_next = '0;
                    if (hit_now)
                    begin
                        cur_column_next       = CC_W'(first_now);
                        span_last_next        = last_now;
                        tx_phase_next         = ddsf_pkg::PH_CURSOR;
                        seq_index_next        = 3'd1;
                        res_next.byte_valid   = 1'b1;
                        res_next.bus_byte     = device_address_reg;
                        res_next.start_before = 1'b1;
                        state_next            = S_OUT;
                    end
                    else if (next_page >= PG_W'(PAGES))
                    begin
                        frame_pending_next  = 1'b0;
                        cur_page_next       = '0;
                        res_next.frame_done = 1'b1;
                        state_next          = S_OUT;
                    end
                    else
                    begin
                        cur_page_next    = next_page;
                        scan_col_next    = '0;
                        issue_done_next  = 1'b0;
                        scan_ctl.restart = 1'b1;
                    end
                end
            end

            S_DREAD:
            begin
                // frame byte is back: send it and mirror it into the shadow
                shown_we            = 1'b1;
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.bus_byte   = frame_q_reg;
                res_next.stop_after = span_end;
                cur_column_next     = next_col;
                if (span_end)
                begin
                    cur_page_next = next_page;
                    tx_phase_next = ddsf_pkg::PH_IDLE;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_addr_reg      <= '0;
            frame_pending_reg <= 1'b0;
            tx_phase_reg      <= ddsf_pkg::PH_IDLE;
            seq_index_reg     <= '0;
            cur_page_reg      <= '0;
            cur_column_reg    <= '0;
            span_last_reg     <= '0;
            scan_col_reg      <= '0;
            issue_done_reg    <= 1'b0;
            rd_v_reg          <= 1'b0;
            rd_col_reg        <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_addr_reg      <= clr_addr_next;
            frame_pending_reg <= frame_pending_next;
            tx_phase_reg      <= tx_phase_next;
            seq_index_reg     <= seq_index_next;
            cur_page_reg      <= cur_page_next;
            cur_column_reg    <= cur_column_next;
            span_last_reg     <= span_last_next;
            scan_col_reg      <= scan_col_next;
            issue_done_reg    <= issue_done_next;
            rd_v_reg          <= rd_v_next;
            rd_col_reg        <= rd_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg  <= ddsf_pkg::COL_OFFSET_RST;
            device_address_reg <= ddsf_pkg::DEV_ADDR_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ddsf_pkg::CFG_COLUMN_OFFSET:  column_offset_reg  <= cfg_data[6:0];
                ddsf_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
            endcase
        end
    end

    // stores: one write and one registered read each per cycle
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_q_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (shown_we)
        begin
            shown_mem[shown_waddr] <= shown_wdata;
        end
        shown_q_reg <= shown_mem[shown_raddr];
    end

    // output beat register
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= res_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_valid    = out_res_reg.byte_valid;
    assign bus_byte      = out_res_reg.bus_byte;
    assign start_before  = out_res_reg.start_before;
    assign stop_after    = out_res_reg.stop_after;
    assign frame_done    = out_res_reg.frame_done;
    assign write_refused = out_res_reg.write_refused;

    // checks
    `DDSF_ASSERT_NOW(a_tx_needs_pending, tx_phase_reg != ddsf_pkg::PH_IDLE, frame_pending_reg, "transmit phase active without a pending frame")
    `DDSF_ASSERT_NOW(a_dread_in_data, state_reg == S_DREAD, tx_phase_reg == ddsf_pkg::PH_DATA, "data read outside data phase")
    `DDSF_ASSERT_NOW(a_col_in_span, tx_phase_reg == ddsf_pkg::PH_DATA, cur_column_reg <= CC_W'(span_last_reg), "data column past span end")
    `DDSF_ASSERT_NEXT(a_data_step_reads, in_valid && in_ready && req_type == ddsf_pkg::REQ_STEP && tx_phase_reg == ddsf_pkg::PH_DATA, state_reg == S_DREAD, "data step did not read the frame store")
    `DDSF_ASSERT_NOW(a_done_alone, out_valid && frame_done, !byte_valid && !write_refused, "frame_done beat carries other flags")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for display_dirty_span_flusher: random and directed beats.
// Depends on ddsf_pkg and the flusher RTL; a scoreboard class predicts every bus beat.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES = 8;
    localparam int WIDTH = 128;
    localparam int CELLS = PAGES * WIDTH;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    // Worst search for a dirty page: every page walked once, plus margin.
    localparam int SETTLE_CYCLES  = PAGES * (WIDTH + 1) + 16;
    // Longest quiet stretch is a settle pause or a full search plus stalls.
    localparam int WATCHDOG_LIMIT = 4 * SETTLE_CYCLES;
    localparam int RANDOM_ITEMS   = 600;

    // The package names codes 0..2 only; 3 is a request the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: a private copy of both stores and the transmit state.
    // predict_item runs on every accepted item and queues the beat it
    // should cause; check_beat pops the oldest one for each output beat.
    // ------------------------------------------------------------------
    class flush_tracker;
        logic [7:0] frame_mem [CELLS];
        logic [7:0] shown_mem [CELLS];
        bit          frame_open;
        logic [1:0]  phase;
        int unsigned seq;
        int unsigned scan_page;
        int unsigned span_col;
        int unsigned span_end;
        logic [6:0]  col_offset;
        logic [7:0]  dev_addr;
        ddsf_pkg::result_t awaited_beats [$];
        int          errors;

        function new();
            foreach (frame_mem[i])
            begin
                frame_mem[i] = 8'h00;
                shown_mem[i] = 8'hFF;
            end
            frame_open = 1'b0;
            phase      = ddsf_pkg::PH_IDLE;
            seq        = 0;
            scan_page  = 0;
            span_col   = 0;
            span_end   = 0;
            col_offset = ddsf_pkg::COL_OFFSET_RST;
            dev_addr   = ddsf_pkg::DEV_ADDR_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] data);
            if (idx == ddsf_pkg::CFG_COLUMN_OFFSET)
                col_offset = data[6:0];
            else
                dev_addr = data;
        endfunction

        // First page from scan_page on where frame and shadow differ,
        // with its first and last differing columns.
        function bit find_dirty_span();
            bit          hit;
            int unsigned base;
            while (scan_page < PAGES)
            begin
                base = scan_page * WIDTH;
                hit  = 1'b0;
                for (int x = 0; x < WIDTH; x++)
                begin
                    if (frame_mem[base + x] != shown_mem[base + x])
                    begin
                        if (!hit)
                        begin
                            span_col = x;
                            hit      = 1'b1;
                        end
                        span_end = x;
                    end
                end
                if (hit)
                    return 1'b1;
                scan_page++;
            end
            return 1'b0;
        endfunction

        // Returns 1 when the item did anything at all.
        function bit predict_item(logic [1:0] req, logic [2:0] pg, logic [6:0] col,
                                  logic [7:0] val);
            ddsf_pkg::result_t beat;
            bit          busy;
            bit          closes;
            logic [7:0]  cursor_col;
            int unsigned at;
            beat = '0;
            busy = frame_open || (phase != ddsf_pkg::PH_IDLE);
            if (req == ddsf_pkg::REQ_WRITE || req == ddsf_pkg::REQ_COMMIT)
            begin
                if (busy)
                begin
                    beat.write_refused = 1'b1;
                    awaited_beats.push_back(beat);
                    return 1'b1;
                end
                if (req == ddsf_pkg::REQ_COMMIT)
                begin
                    frame_open = 1'b1;
                    scan_page  = 0;
                end
                else
                    frame_mem[int'(pg) * WIDTH + int'(col)] = val;
                return 1'b1;
            end
            if (req != ddsf_pkg::REQ_STEP)
                return 1'b0;

            if (phase == ddsf_pkg::PH_IDLE)
            begin
                if (!frame_open)
                    return 1'b0;
                if (!find_dirty_span())
                begin
                    frame_open      = 1'b0;
                    scan_page       = 0;
                    beat.frame_done = 1'b1;
                    awaited_beats.push_back(beat);
                    return 1'b1;
                end
                phase = ddsf_pkg::PH_CURSOR;
                seq   = 0;
            end

            beat.byte_valid = 1'b1;
            case (phase)
                ddsf_pkg::PH_CURSOR:
                begin
                    cursor_col = 8'(span_col) + {1'b0, col_offset};
                    if (seq == 0)
                        beat.bus_byte = dev_addr;
                    else if (seq == 1)
                        beat.bus_byte = ddsf_pkg::CTRL_CMD;
                    else if (seq == 2)
                        beat.bus_byte = ddsf_pkg::CMD_PAGE | {4'h0, 4'(scan_page)};
                    else if (seq == 3)
                        beat.bus_byte = ddsf_pkg::CMD_COL_HI | {4'h0, cursor_col[7:4]};
                    else
                        beat.bus_byte = cursor_col & ddsf_pkg::NIBBLE_MASK;
                    beat.start_before = (seq == 0);
                    beat.stop_after   = (seq >= 4);
                    if (seq >= 4)
                    begin
                        phase = ddsf_pkg::PH_HEADER;
                        seq   = 0;
                    end
                    else
                        seq++;
                end
                ddsf_pkg::PH_HEADER:
                begin
                    if (seq == 0)
                    begin
                        seq               = 1;
                        beat.bus_byte     = dev_addr;
                        beat.start_before = 1'b1;
                    end
                    else
                    begin
                        seq           = 0;
                        phase         = ddsf_pkg::PH_DATA;
                        beat.bus_byte = ddsf_pkg::CTRL_DATA;
                    end
                end
                default:
                begin
                    if (scan_page < PAGES && span_col < WIDTH)
                    begin
                        at            = scan_page * WIDTH + span_col;
                        beat.bus_byte = frame_mem[at];
                        shown_mem[at] = frame_mem[at];
                    end
                    span_col++;
                    closes = (span_col > span_end) || (span_col >= WIDTH);
                    if (closes)
                    begin
                        scan_page++;
                        phase = ddsf_pkg::PH_IDLE;
                    end
                    beat.stop_after = closes;
                end
            endcase
            awaited_beats.push_back(beat);
            return 1'b1;
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(ddsf_pkg::result_t seen);
            ddsf_pkg::result_t want;
            if (awaited_beats.size() == 0)
            begin
                $error("output beat with no expectation waiting: 0x%04h", seen);
                errors++;
                return;
            end
            want = awaited_beats.pop_front();
            compare_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
            compare_field("bus_byte", want.bus_byte, seen.bus_byte);
            compare_field("start_before", 8'(want.start_before), 8'(seen.start_before));
            compare_field("stop_after", 8'(want.stop_after), 8'(seen.stop_after));
            compare_field("frame_done", 8'(want.frame_done), 8'(seen.frame_done));
            compare_field("write_refused", 8'(want.write_refused),
                          8'(seen.write_refused));
        endfunction

        function bit drained();
            return awaited_beats.size() == 0;
        endfunction

        function void report_leftovers();
            if (awaited_beats.size() != 0)
            begin
                $error("%0d expected beats never arrived", awaited_beats.size());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals. Everything is known from time zero.
    // ------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [1:0] req_type     = ddsf_pkg::REQ_WRITE;
    logic [2:0] page         = 3'd0;
    logic [6:0] column       = 7'd0;
    logic [7:0] pixel_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       byte_valid;
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       frame_done;
    logic       write_refused;
    logic       cfg_write_en = 1'b0;
    logic       cfg_index    = ddsf_pkg::CFG_COLUMN_OFFSET;
    logic [7:0] cfg_data     = 8'h00;

    flush_tracker      tracker;
    ddsf_pkg::result_t seen_beat;
    int unsigned  quiet_cycles = 0;
    int unsigned  stall_left   = 0;
    int unsigned  live_items   = 0;
    // When set, neither side inserts gaps: back-to-back beats.
    bit           steady       = 1'b0;

    display_dirty_span_flusher #(
        .PAGES (PAGES),
        .WIDTH (WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .page          (page),
        .column        (column),
        .pixel_byte    (pixel_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_valid    (byte_valid),
        .bus_byte      (bus_byte),
        .start_before  (start_before),
        .stop_after    (stop_after),
        .frame_done    (frame_done),
        .write_refused (write_refused),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Gap lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: drops ready for random stretches, changes only on falling edges.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0)
                stall_left = gap_len();
        end
    end

    // Output monitor and watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_beat = {byte_valid, bus_byte, start_before, stop_after,
                             frame_done, write_refused};
                tracker.check_beat(seen_beat);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. Each one starts and ends on a falling edge; valid is
    // left high after a beat so the next item can follow with no gap.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] req, input logic [2:0] pg,
                             input logic [6:0] col, input logic [7:0] val);
        int unsigned gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        page       <= pg;
        column     <= col;
        pixel_byte <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (tracker.predict_item(req, pg, col, val))
            live_items++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 3'($urandom()), 7'($urandom()),
                  8'($urandom()));
    endtask

    task automatic pause_input(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold the sender until every queued beat has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (!tracker.drained())
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        cfg_index    <= idx;
        cfg_data     <= data;
        cfg_write_en <= 1'b1;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Registers change only with the block quiet: drain, then wait out a
    // possible full dirty-page search that leaves no beat behind.
    task automatic reconfigure(input logic [7:0] offset, input logic [7:0] addr);
        wait_drained();
        pause_input(SETTLE_CYCLES);
        write_reg(ddsf_pkg::CFG_COLUMN_OFFSET, offset);
        write_reg(ddsf_pkg::CFG_DEVICE_ADDRESS, addr);
    endtask

    // Step until the frame reports done; noise_pct of the items are noise.
    task automatic step_until_done(input int unsigned noise_pct);
        while (tracker.frame_open)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            else
                send_item(ddsf_pkg::REQ_STEP, 3'($urandom()), 7'($urandom()),
                          8'($urandom()));
        end
    endtask

    task automatic run_frame(input int unsigned noise_pct);
        send_item(ddsf_pkg::REQ_COMMIT, 3'($urandom()), 7'($urandom()), 8'($urandom()));
        step_until_done(noise_pct);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        int unsigned count;
        logic [2:0]  hot_page;
        logic [2:0]  pg;
        logic [6:0]  base_col;
        logic [6:0]  col;
        logic [7:0]  offset;
        logic [7:0]  addr;

        tracker = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values. Nothing pending: a step and
        // an unused request code both do nothing.
        send_item(ddsf_pkg::REQ_STEP, 3'd0, 7'd0, 8'h00);
        send_item(REQ_UNUSED, 3'd7, 7'd127, 8'hFF);
        send_item(ddsf_pkg::REQ_WRITE, 3'd0, 7'd0, 8'h00);
        // Same as the shadow's reset value, so this cell stays clean.
        send_item(ddsf_pkg::REQ_WRITE, 3'd7, 7'd127, 8'hFF);
        send_item(ddsf_pkg::REQ_WRITE, 3'd3, 7'd64, 8'hA5);
        send_item(ddsf_pkg::REQ_COMMIT, 3'd0, 7'd0, 8'h00);
        // First step: search hits page 0, address byte goes out with start.
        send_item(ddsf_pkg::REQ_STEP, 3'd0, 7'd0, 8'h00);
        // Frame pending: write and commit are refused, code 3 ignored.
        send_item(ddsf_pkg::REQ_WRITE, 3'd5, 7'd5, 8'h11);
        send_item(ddsf_pkg::REQ_COMMIT, 3'd0, 7'd0, 8'h00);
        send_item(REQ_UNUSED, 3'd0, 7'd0, 8'h00);
        // After reset every cell but one differs: full-width spans on pages 0 to 6, columns 0 to 126 on page 7.
        step_until_done(0);
        send_item(ddsf_pkg::REQ_STEP, 3'd0, 7'd0, 8'h00);
        // Commit with nothing dirty: one full search, then frame done.
        send_item(ddsf_pkg::REQ_COMMIT, 3'd0, 7'd0, 8'h00);
        send_item(ddsf_pkg::REQ_STEP, 3'd0, 7'd0, 8'h00);

        // Largest offset on the last column: cursor column reaches 254, its highest value.
        reconfigure(8'd127, 8'hFF);
        send_item(ddsf_pkg::REQ_WRITE, 3'd0, 7'd127, 8'h01);
        send_item(ddsf_pkg::REQ_WRITE, 3'd7, 7'd126, 8'h00);
        run_frame(0);

        // Zero offset and address; page 7 dirty only at both ends.
        reconfigure(8'd0, 8'h00);
        send_item(ddsf_pkg::REQ_WRITE, 3'd7, 7'd0, 8'h3C);
        send_item(ddsf_pkg::REQ_WRITE, 3'd7, 7'd127, 8'hC3);
        run_frame(0);

        // Random part: mostly well-formed write/commit/step-to-done
        // sequences, some noise bursts and the odd full drain.
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 75)
            begin
                hot_page = 3'($urandom());
                base_col = 7'($urandom());
                count    = $urandom_range(1, 8);
                repeat (count)
                begin
                    if ($urandom_range(0, 5) == 0)
                        pg = 3'($urandom());
                    else
                        pg = hot_page + 3'($urandom_range(0, 1));
                    if ($urandom_range(0, 7) == 0)
                        col = 7'($urandom());
                    else
                        col = base_col + 7'($urandom_range(0, 12));
                    send_item(ddsf_pkg::REQ_WRITE, pg, col, 8'($urandom()));
                end
                run_frame(8);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
            else
                wait_drained();

            if (!tracker.frame_open && $urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    offset = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd127;
                    addr   = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                end
                else
                begin
                    offset = 8'($urandom());
                    addr   = 8'($urandom());
                end
                reconfigure(offset, addr);
            end
        end

        steady = 1'b0;
        wait_drained();
        pause_input(SETTLE_CYCLES);
        tracker.report_leftovers();
        if (tracker.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
